FILE: src/glsk_pkg.sv
// Package for the gateway link session keeper: beat types, packet signatures,
// send kinds and configuration register indexes. No dependencies.
package glsk_pkg;

  localparam logic [31:0] SIG_INIT      = 32'h494E_4954;
  localparam logic [31:0] SIG_DSTR      = 32'h4453_5452;
  localparam logic [15:0] TYPE_POLL     = 16'h7300;
  localparam logic [15:0] TYPE_ACK      = 16'h7200;
  localparam logic [15:0] FLAG_SENT     = TYPE_POLL ^ TYPE_ACK;
  localparam logic [10:0] HEADER_BYTES  = 11'd10;

  localparam logic        OP_PACKET     = 1'b0;
  localparam logic        OP_TICK       = 1'b1;

  localparam logic [1:0]  KIND_NONE     = 2'd0;
  localparam logic [1:0]  KIND_INIT_ACK = 2'd1;
  localparam logic [1:0]  KIND_DSTR_ACK = 2'd2;
  localparam logic [1:0]  KIND_POLL     = 2'd3;

  localparam int          CFG_IDX_W         = 2;
  localparam int          CFG_DATA_W        = 16;
  localparam logic [1:0]  REG_POLL_INTERVAL = 2'd0;
  localparam logic [1:0]  REG_DATA_TIMEOUT  = 2'd1;

  localparam logic [7:0]  POLL_INTERVAL_RST = 8'd15;
  localparam logic [15:0] DATA_TIMEOUT_RST  = 16'd60;

  typedef struct packed {
    logic        op;
    logic [31:0] signature;
    logic [15:0] pkt_type;
    logic [15:0] pkt_number;
    logic [10:0] pkt_length;
    logic [31:0] remote_addr;
    logic [15:0] remote_port;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  send_kind;
    logic [15:0] send_number;
    logic [31:0] dest_addr;
    logic [15:0] dest_port;
    logic        link_up;
  } out_beat_t;

endpackage

FILE: src/gateway_link_session_keeper.sv
// Top level of the gateway link session keeper: configuration registers,
// result register and handshakes. Depends on glsk_pkg and glsk_engine.
//
// Usage: the input channel carries either a received packet header or a
// one-second tick (op set). Every accepted beat yields exactly one result
// beat with the send kind, the sequence number to send, the latched peer
// address and port, and the link state.
// The result is registered: a beat accepted at one edge is offered on the output
// channel from the next cycle on. Throughput is one beat per cycle while the
// receiver takes the results; the session state is updated in the same edge that
// accepts the beat, so the next beat sees it at once.
// When the receiver stalls, the result is held in the output register and
// in_ready stays high only if that result is taken in the same cycle.
// Configuration writes take effect at the edge where cfg_we is high and
// should only be made while no beat is in flight.
// Reset clears the clock, both deadlines, the sequence counter and the peer,
// drops the output beat and restores the poll interval to 15 s and the data
// timeout to 60 s.
module gateway_link_session_keeper (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  glsk_pkg::in_beat_t                  in_beat,
  output logic                                out_valid,
  input  logic                                out_ready,
  output glsk_pkg::out_beat_t                 out_beat,
  input  logic                                cfg_we,
  input  logic [glsk_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [glsk_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [7:0]          poll_interval_r;
  logic [15:0]         data_timeout_r;
  logic                out_valid_r;
  glsk_pkg::out_beat_t out_beat_r;
  glsk_pkg::out_beat_t result;
  logic                step;

  assign in_ready  = !out_valid_r || out_ready;
  assign step      = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  glsk_engine u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .in_beat       (in_beat),
    .poll_interval (poll_interval_r),
    .data_timeout  (data_timeout_r),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_interval_r <= glsk_pkg::POLL_INTERVAL_RST;
      data_timeout_r  <= glsk_pkg::DATA_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        glsk_pkg::REG_POLL_INTERVAL: poll_interval_r <= cfg_wdata[7:0];
        glsk_pkg::REG_DATA_TIMEOUT:  data_timeout_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_beat_r <= result;
    end
  end

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("accepted beat produced no result");

  a_silent_number_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_beat_r.send_kind == glsk_pkg::KIND_NONE)
      |-> (out_beat_r.send_number == 16'd0))
    else $error("nothing sent but send number is nonzero");

  a_tick_no_ack: assert property (@(posedge clk) disable iff (!rst_n)
    step && (in_beat.op == glsk_pkg::OP_TICK)
      |=> (out_beat_r.send_kind == glsk_pkg::KIND_NONE)
       || (out_beat_r.send_kind == glsk_pkg::KIND_POLL))
    else $error("tick produced an acknowledge");

  a_packet_no_poll: assert property (@(posedge clk) disable iff (!rst_n)
    step && (in_beat.op == glsk_pkg::OP_PACKET)
      |=> (out_beat_r.send_kind != glsk_pkg::KIND_POLL))
    else $error("packet header produced a keepalive poll");

endmodule

FILE: src/glsk_engine.sv
// Session state and per-beat decision logic of the gateway link session keeper.
// Depends on glsk_pkg for beat types, signatures and send kinds.
module glsk_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  glsk_pkg::in_beat_t in_beat,
  input  logic [7:0]        poll_interval,
  input  logic [15:0]       data_timeout,
  output glsk_pkg::out_beat_t result
);

  logic [31:0] clock_r, clock_nxt;
  logic [31:0] poll_dl_r, poll_dl_nxt;
  logic [31:0] data_dl_r, data_dl_nxt;
  logic [15:0] seq_r, seq_nxt;
  logic [31:0] peer_addr_r, peer_addr_nxt;
  logic [15:0] peer_port_r, peer_port_nxt;

  logic [31:0] clock_inc;
  logic        len_ok;
  logic        is_init;
  logic        is_dstr;
  logic        poll_hit;
  logic        link_drop;
  logic        init_hit;
  logic        dstr_sent;
  logic        dstr_ack;
  logic [1:0]  kind;
  logic [15:0] number;

  always_comb begin
    clock_inc = clock_r + 32'd1;
    len_ok    = in_beat.pkt_length >= glsk_pkg::HEADER_BYTES;
    is_init   = len_ok && (in_beat.signature == glsk_pkg::SIG_INIT);
    is_dstr   = len_ok && (in_beat.signature == glsk_pkg::SIG_DSTR);
    poll_hit  = (clock_inc > poll_dl_r) && (clock_inc < data_dl_r);
    link_drop = (clock_inc >= data_dl_r) && (poll_dl_r != 32'd0);
    init_hit  = is_init && (in_beat.pkt_type == glsk_pkg::TYPE_POLL) && (clock_r > poll_dl_r);
    dstr_sent = is_dstr && ((in_beat.pkt_type & glsk_pkg::FLAG_SENT) != 16'd0);
    dstr_ack  = is_dstr && (in_beat.pkt_type == glsk_pkg::TYPE_ACK);

    clock_nxt     = clock_r;
    poll_dl_nxt   = poll_dl_r;
    data_dl_nxt   = data_dl_r;
    seq_nxt       = seq_r;
    peer_addr_nxt = peer_addr_r;
    peer_port_nxt = peer_port_r;
    kind          = glsk_pkg::KIND_NONE;
    number        = 16'd0;

    if (in_beat.op == glsk_pkg::OP_TICK) begin
      clock_nxt = clock_inc;
      if (poll_hit) begin
        kind        = glsk_pkg::KIND_POLL;
        number      = seq_r;
        poll_dl_nxt = clock_inc + {24'd0, poll_interval};
      end
      if (link_drop) begin
        poll_dl_nxt = 32'd0;
      end
    end else begin
      if (init_hit) begin
        peer_addr_nxt = in_beat.remote_addr;
        peer_port_nxt = in_beat.remote_port;
        kind          = glsk_pkg::KIND_INIT_ACK;
        number        = seq_r;
        seq_nxt       = in_beat.pkt_number + 16'd1;
        poll_dl_nxt   = clock_r + {24'd0, poll_interval};
        data_dl_nxt   = clock_r + {16'd0, data_timeout};
      end
      if (dstr_sent) begin
        kind    = glsk_pkg::KIND_DSTR_ACK;
        number  = seq_r;
        seq_nxt = in_beat.pkt_number + 16'd1;
      end
      if (dstr_ack) begin
        data_dl_nxt = clock_r + {16'd0, data_timeout};
      end
    end
  end

  always_comb begin
    result.send_kind   = kind;
    result.send_number = number;
    result.dest_addr   = peer_addr_nxt;
    result.dest_port   = peer_port_nxt;
    result.link_up     = poll_dl_nxt != 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r     <= 32'd0;
      poll_dl_r   <= 32'd0;
      data_dl_r   <= 32'd0;
      seq_r       <= 16'd0;
      peer_addr_r <= 32'd0;
      peer_port_r <= 16'd0;
    end else if (step) begin
      clock_r     <= clock_nxt;
      poll_dl_r   <= poll_dl_nxt;
      data_dl_r   <= data_dl_nxt;
      seq_r       <= seq_nxt;
      peer_addr_r <= peer_addr_nxt;
      peer_port_r <= peer_port_nxt;
    end
  end

endmodule

FILE: bench/gateway_link_session_keeper_test.sv
`timescale 1ns / 100ps
// Self-checking bench for gateway_link_session_keeper: random packet headers and ticks,
// checked beat by beat against an in-bench model of the session state.
// Depends on glsk_pkg and the RTL of the block.
module gateway_link_session_keeper_test;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASES = 8;
  localparam int PHASE_BEATS = 135;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  glsk_pkg::in_beat_t in_beat = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  glsk_pkg::out_beat_t out_beat;
  logic cfg_we = 1'b0;
  logic [glsk_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [glsk_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  glsk_pkg::in_beat_t pending_beats[$];
  glsk_pkg::out_beat_t expected_results[$];
  int mismatches = 0;
  int burst_left = 0;
  int gap_left = 0;
  int ready_hold = 0;
  int quiet_cycles = 0;
  glsk_pkg::out_beat_t want;

  // Model of the session state and its copy of the registers.
  logic [7:0] poll_ivl;
  logic [15:0] data_tmo;
  logic [31:0] clk_secs;
  logic [31:0] poll_dl;
  logic [31:0] data_dl;
  logic [15:0] seq_num;
  logic [31:0] peer_ip;
  logic [15:0] peer_udp;

  gateway_link_session_keeper dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_beat(in_beat),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_beat(out_beat),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic void session_clear();
    poll_ivl = glsk_pkg::POLL_INTERVAL_RST;
    data_tmo = glsk_pkg::DATA_TIMEOUT_RST;
    clk_secs = '0;
    poll_dl = '0;
    data_dl = '0;
    seq_num = '0;
    peer_ip = '0;
    peer_udp = '0;
  endfunction

  function automatic glsk_pkg::out_beat_t session_step(input glsk_pkg::in_beat_t b);
    glsk_pkg::out_beat_t r;
    r = '0;
    if (b.op == glsk_pkg::OP_TICK) begin
      clk_secs = clk_secs + 32'd1;
      if (clk_secs > poll_dl && clk_secs < data_dl) begin
        r.send_kind = glsk_pkg::KIND_POLL;
        r.send_number = seq_num;
        poll_dl = clk_secs + {24'd0, poll_ivl};
      end
      if (clk_secs >= data_dl && poll_dl != 32'd0) poll_dl = '0;
    end else if (b.pkt_length >= glsk_pkg::HEADER_BYTES) begin
      if (b.signature == glsk_pkg::SIG_INIT) begin
        if (b.pkt_type == glsk_pkg::TYPE_POLL && clk_secs > poll_dl) begin
          peer_ip = b.remote_addr;
          peer_udp = b.remote_port;
          r.send_kind = glsk_pkg::KIND_INIT_ACK;
          r.send_number = seq_num;
          seq_num = b.pkt_number + 16'd1;
          poll_dl = clk_secs + {24'd0, poll_ivl};
          data_dl = clk_secs + {16'd0, data_tmo};
        end
      end else if (b.signature == glsk_pkg::SIG_DSTR) begin
        if ((b.pkt_type & glsk_pkg::FLAG_SENT) != 16'd0) begin
          r.send_kind = glsk_pkg::KIND_DSTR_ACK;
          r.send_number = seq_num;
          seq_num = b.pkt_number + 16'd1;
        end
        if (b.pkt_type == glsk_pkg::TYPE_ACK) data_dl = clk_secs + {16'd0, data_tmo};
      end
    end
    r.dest_addr = peer_ip;
    r.dest_port = peer_udp;
    r.link_up = (poll_dl != 32'd0);
    return r;
  endfunction

  function automatic glsk_pkg::in_beat_t packet(input logic [31:0] sig,
                                                input logic [15:0] ptype,
                                                input logic [15:0] pnum,
                                                input logic [10:0] len,
                                                input logic [31:0] addr,
                                                input logic [15:0] port);
    glsk_pkg::in_beat_t b;
    b.op = glsk_pkg::OP_PACKET;
    b.signature = sig;
    b.pkt_type = ptype;
    b.pkt_number = pnum;
    b.pkt_length = len;
    b.remote_addr = addr;
    b.remote_port = port;
    return b;
  endfunction

  function automatic glsk_pkg::in_beat_t random_beat(input int tick_pct);
    glsk_pkg::in_beat_t b;
    int pick;
    b = packet($urandom, 16'($urandom), 16'($urandom), 11'($urandom), $urandom,
               16'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < tick_pct) begin
      b.op = glsk_pkg::OP_TICK;
    end else if (pick < tick_pct + 15) begin
      b.signature = glsk_pkg::SIG_INIT;
      b.pkt_type = glsk_pkg::TYPE_POLL;
      b.pkt_length = 11'($urandom_range(10, 2047));
    end else if (pick < tick_pct + 30) begin
      b.signature = glsk_pkg::SIG_DSTR;
      b.pkt_type = b.pkt_type | glsk_pkg::FLAG_SENT;
      b.pkt_length = 11'($urandom_range(10, 2047));
    end else if (pick < tick_pct + 42) begin
      b.signature = glsk_pkg::SIG_DSTR;
      b.pkt_type = glsk_pkg::TYPE_ACK;
      b.pkt_length = 11'($urandom_range(10, 2047));
    end else begin
      case ($urandom_range(0, 3))
        0: ;
        1: begin
          b.signature = $urandom_range(0, 1) ? glsk_pkg::SIG_INIT : glsk_pkg::SIG_DSTR;
          b.pkt_length = 11'($urandom_range(0, 9));
        end
        2: begin
          b.signature = glsk_pkg::SIG_INIT;
          b.pkt_length = 11'($urandom_range(10, 2047));
        end
        default: begin
          b.signature = glsk_pkg::SIG_DSTR;
          b.pkt_type = b.pkt_type & ~glsk_pkg::FLAG_SENT;
          b.pkt_length = 11'($urandom_range(10, 2047));
        end
      endcase
    end
    return b;
  endfunction

  function automatic void note_mismatch(input string field, input logic [31:0] got,
                                        input logic [31:0] exp_val);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, field, exp_val, got);
    end
  endfunction

  task automatic write_reg(input logic [glsk_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == glsk_pkg::REG_POLL_INTERVAL) poll_ivl = value[7:0];
    else if (idx == glsk_pkg::REG_DATA_TIMEOUT) data_tmo = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Driver: bursts of beats separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) expected_results.push_back(session_step(in_beat));
      if (in_valid && !in_ready) begin
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_beats.size() != 0) begin
        in_valid <= 1'b1;
        in_beat <= pending_beats.pop_front();
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks result beats and stalls the output on its own pattern.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          note_mismatch("unexpected beat", 32'd0, 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_beat.send_kind !== want.send_kind)
            note_mismatch("send_kind", 32'(out_beat.send_kind), 32'(want.send_kind));
          if (out_beat.send_number !== want.send_number)
            note_mismatch("send_number", 32'(out_beat.send_number), 32'(want.send_number));
          if (out_beat.dest_addr !== want.dest_addr)
            note_mismatch("dest_addr", out_beat.dest_addr, want.dest_addr);
          if (out_beat.dest_port !== want.dest_port)
            note_mismatch("dest_port", 32'(out_beat.dest_port), 32'(want.dest_port));
          if (out_beat.link_up !== want.link_up)
            note_mismatch("link_up", 32'(out_beat.link_up), 32'(want.link_up));
        end
      end
      if (ready_hold > 0) begin
        ready_hold--;
      end else if ($urandom_range(0, 9) < 3) begin
        out_ready <= 1'b0;
        ready_hold = $urandom_range(1, 6);
      end else begin
        out_ready <= 1'b1;
        ready_hold = $urandom_range(1, 40);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[gateway_link_session_keeper] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned ivl_plan[PHASES];
    int unsigned tmo_plan[PHASES];
    int unsigned ivl;
    int unsigned tmo;
    glsk_pkg::in_beat_t tick_beat;

    ivl_plan = '{15, 1, 255, 0, 3, 0, 0, 2};
    tmo_plan = '{60, 1, 65535, 0, 20, 0, 30, 5};
    session_clear();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    tick_beat = '0;
    tick_beat.op = glsk_pkg::OP_TICK;
    // An INIT poll before the first tick is not past the poll deadline.
    pending_beats.push_back(packet(glsk_pkg::SIG_INIT, glsk_pkg::TYPE_POLL, 16'h1234, 11'd10,
                                   32'h0A000001, 16'h4000));
    pending_beats.push_back('1);
    pending_beats.push_back(packet(glsk_pkg::SIG_INIT, glsk_pkg::TYPE_POLL, 16'hFFFF, 11'd9,
                                   32'h0A000002, 16'h4001));
    pending_beats.push_back(packet(glsk_pkg::SIG_INIT, glsk_pkg::TYPE_POLL, 16'hFFFF, 11'd10,
                                   32'hFFFFFFFF, 16'hFFFF));
    pending_beats.push_back(packet(glsk_pkg::SIG_INIT, glsk_pkg::TYPE_POLL, 16'h0000,
                                   11'd2047, 32'h0, 16'h0));
    // DSTR from a stranger is answered to the latched peer; the counter wraps.
    pending_beats.push_back(packet(glsk_pkg::SIG_DSTR, glsk_pkg::TYPE_POLL, 16'hFFFF, 11'd10,
                                   32'h01020304, 16'h0001));
    pending_beats.push_back(packet(glsk_pkg::SIG_DSTR, 16'hFFFF, 16'h00FF, 11'd2047, 32'h0,
                                   16'h0));
    pending_beats.push_back(packet(glsk_pkg::SIG_DSTR, glsk_pkg::TYPE_ACK, 16'h0000, 11'd10,
                                   32'h0, 16'h0));
    pending_beats.push_back(packet(glsk_pkg::SIG_DSTR, 16'h0000, 16'h5555, 11'd100, 32'h0,
                                   16'h0));
    pending_beats.push_back(packet(glsk_pkg::SIG_DSTR, glsk_pkg::TYPE_POLL, 16'h0005, 11'd9,
                                   32'h0, 16'h0));
    pending_beats.push_back(packet(32'h0, glsk_pkg::TYPE_POLL, 16'h0, 11'd2047, 32'h0,
                                   16'h0));
    pending_beats.push_back(packet(32'hFFFFFFFF, glsk_pkg::TYPE_ACK, 16'hFFFF, 11'd2047,
                                   32'hFFFFFFFF, 16'hFFFF));
    pending_beats.push_back(packet(glsk_pkg::SIG_INIT, glsk_pkg::TYPE_ACK, 16'h0001, 11'd50,
                                   32'h0, 16'h0));
    repeat (12) pending_beats.push_back(tick_beat);

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_idle();
        ivl = ivl_plan[p];
        tmo = tmo_plan[p];
        if (p == 5) begin
          ivl = $urandom_range(1, 255);
          tmo = $urandom_range(1, 400);
        end
        write_reg(glsk_pkg::REG_POLL_INTERVAL, ivl[15:0]);
        write_reg(glsk_pkg::REG_DATA_TIMEOUT, tmo[15:0]);
      end
      for (int k = 0; k < PHASE_BEATS; k++) pending_beats.push_back(random_beat(45));
    end

    wait_idle();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[gateway_link_session_keeper] OK");
    end else begin
      $display("[gateway_link_session_keeper] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
src/glsk_pkg.sv
src/glsk_engine.sv
src/gateway_link_session_keeper.sv
bench/gateway_link_session_keeper_test.sv
